@@ rtl/mhs_pkg.sv @@
// Shared types and constants for the min-heap with heapsort block.
`timescale 1ns / 1ps

package mhs_pkg;

  // Fixed field widths of the channels
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SORT = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_R1,
    S_POP_R2,
    S_PEEK_R,
    S_SRT_R1,
    S_SRT_R2,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_SRT_NEXT,
    S_EM_RD,
    S_EM_OUT,
    S_RESULT
  } state_t;

  // One result beat
  typedef struct packed {
    logic [VALUE_W-1:0] result_value;
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
    logic               last_of_run;
  } rsp_t;

endpackage

@@ rtl/mhs_req_if.sv @@
// Request channel: one operation per beat.
`timescale 1ns / 1ps

interface mhs_req_if;
  logic                                valid;
  logic                                ready;
  logic [mhs_pkg::OP_W-1:0]            operation;
  logic signed [mhs_pkg::VALUE_W-1:0]  push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

@@ rtl/mhs_rsp_if.sv @@
// Result channel: one result item per beat.
`timescale 1ns / 1ps

interface mhs_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [mhs_pkg::VALUE_W-1:0]  result_value;
  logic [1:0]                          status;
  logic [mhs_pkg::COUNT_W-1:0]         entry_count;
  logic                                last_of_run;

  modport source (output valid, output result_value, output status,
                  output entry_count, output last_of_run, input ready);
  modport sink   (input valid, input result_value, input status,
                  input entry_count, input last_of_run, output ready);
endinterface

@@ rtl/mhs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mhs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mhs_engine.sv @@
// Heap sequencer: push, pop, peek and heapsort over the heap RAM.
`timescale 1ns / 1ps

module mhs_engine #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  mhs_pkg::op_t                       req_op,
  input  logic signed [mhs_pkg::VALUE_W-1:0] req_value,
  output logic                               res_valid,
  input  logic                               res_ready,
  output mhs_pkg::rsp_t                      res
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = AW + 2;

  mhs_pkg::state_t state, state_next;
  mhs_pkg::op_t    op_q, op_q_next;
  mhs_pkg::status_t res_st, res_st_next;

  logic [AW-1:0]                cur, cur_next;
  logic signed [DATA_WIDTH-1:0] val, val_next;
  logic signed [DATA_WIDTH-1:0] lval, lval_next;
  logic signed [DATA_WIDTH-1:0] res_val, res_val_next;
  logic                         has_r, has_r_next;
  logic [CW-1:0]                limit, limit_next;
  logic [CW-1:0]                cnt, cnt_next;
  logic [CW-1:0]                idx, idx_next;

  // RAM port signals
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic signed [DATA_WIDTH-1:0] ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic signed [DATA_WIDTH-1:0] rdata;

  // Index arithmetic and compares
  logic                         accept;
  logic [AW-1:0]                parent;
  logic [XW-1:0]                lc, rc, limit_x;
  logic                         go_l, go_r, move, up_less;
  logic signed [DATA_WIDTH-1:0] best_l, best;
  logic [AW-1:0]                child;
  logic                         full, empty, em_last;
  mhs_pkg::state_t              dn_done;

  mhs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign req_ready = (state == mhs_pkg::S_IDLE);
  assign accept    = req_valid && req_ready;
  assign full      = (cnt == CW'(DEPTH));
  assign empty     = (cnt == '0);

  assign parent  = (cur - AW'(1)) >> 1;
  assign lc      = {1'b0, cur, 1'b1};
  assign rc      = {1'b0, cur, 1'b0} + XW'(2);
  assign limit_x = XW'(limit);
  assign up_less = (val < rdata);

  // Sift-down selection: hole value against left then right child
  assign go_l   = (lval < val);
  assign best_l = go_l ? lval : val;
  assign go_r   = has_r && (rdata < best_l);
  assign move   = go_l || go_r;
  assign best   = go_r ? rdata : lval;
  assign child  = go_r ? AW'(rc) : AW'(lc);

  assign em_last = (idx == cnt - CW'(1));
  assign dn_done = (op_q == mhs_pkg::OP_SORT) ? mhs_pkg::S_SRT_NEXT : mhs_pkg::S_RESULT;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mhs_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req_op)
            mhs_pkg::OP_PUSH: state_next = full ? mhs_pkg::S_RESULT : mhs_pkg::S_UP_RD;
            mhs_pkg::OP_POP:  state_next = empty ? mhs_pkg::S_RESULT : mhs_pkg::S_POP_R1;
            mhs_pkg::OP_PEEK: state_next = empty ? mhs_pkg::S_RESULT : mhs_pkg::S_PEEK_R;
            mhs_pkg::OP_SORT: begin
              if (empty) state_next = mhs_pkg::S_RESULT;
              else if (cnt == CW'(1)) state_next = mhs_pkg::S_EM_RD;
              else state_next = mhs_pkg::S_SRT_R1;
            end
            default: state_next = mhs_pkg::S_IDLE;
          endcase
        end
      end
      mhs_pkg::S_UP_RD:  state_next = (cur == '0) ? mhs_pkg::S_RESULT : mhs_pkg::S_UP_CMP;
      mhs_pkg::S_UP_CMP: state_next = up_less ? mhs_pkg::S_UP_RD : mhs_pkg::S_RESULT;
      mhs_pkg::S_POP_R1: state_next = mhs_pkg::S_POP_R2;
      mhs_pkg::S_POP_R2: state_next = empty ? mhs_pkg::S_RESULT : mhs_pkg::S_DN_RDL;
      mhs_pkg::S_PEEK_R: state_next = mhs_pkg::S_RESULT;
      mhs_pkg::S_SRT_R1: state_next = mhs_pkg::S_SRT_R2;
      mhs_pkg::S_SRT_R2: state_next = mhs_pkg::S_DN_RDL;
      mhs_pkg::S_DN_RDL: state_next = (lc >= limit_x) ? dn_done : mhs_pkg::S_DN_RDR;
      mhs_pkg::S_DN_RDR: state_next = mhs_pkg::S_DN_CMP;
      mhs_pkg::S_DN_CMP: state_next = move ? mhs_pkg::S_DN_RDL : dn_done;
      mhs_pkg::S_SRT_NEXT: begin
        state_next = (idx == CW'(1)) ? mhs_pkg::S_EM_RD : mhs_pkg::S_SRT_R1;
      end
      mhs_pkg::S_EM_RD:  state_next = mhs_pkg::S_EM_OUT;
      mhs_pkg::S_EM_OUT: begin
        if (res_ready) state_next = em_last ? mhs_pkg::S_IDLE : mhs_pkg::S_EM_RD;
      end
      mhs_pkg::S_RESULT: begin
        if (res_ready) state_next = mhs_pkg::S_IDLE;
      end
      default: state_next = mhs_pkg::S_IDLE;
    endcase
  end

  // Datapath controls, RAM accesses and result beat
  always_comb begin
    op_q_next    = op_q;
    res_st_next  = res_st;
    res_val_next = res_val;
    cur_next     = cur;
    val_next     = val;
    lval_next    = lval;
    has_r_next   = has_r;
    limit_next   = limit;
    cnt_next     = cnt;
    idx_next     = idx;
    ram_we       = 1'b0;
    ram_waddr    = cur;
    ram_wdata    = val;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    res_valid    = 1'b0;
    res.result_value = mhs_pkg::VALUE_W'(res_val);
    res.status       = res_st;
    res.entry_count  = mhs_pkg::COUNT_W'(cnt);
    res.last_of_run  = 1'b1;

    unique case (state)
      mhs_pkg::S_IDLE: begin
        if (accept) begin
          op_q_next    = req_op;
          res_val_next = '0;
          res_st_next  = mhs_pkg::ST_OK;
          // root read is harmless for every operation
          ram_re       = 1'b1;
          if (req_op == mhs_pkg::OP_PUSH) begin
            if (full) begin
              res_st_next = mhs_pkg::ST_FULL;
            end else begin
              cur_next = AW'(cnt);
              val_next = DATA_WIDTH'(req_value);
              cnt_next = cnt + CW'(1);
            end
          end else if (empty) begin
            res_st_next = mhs_pkg::ST_EMPTY;
          end else begin
            idx_next = cnt - CW'(1);
          end
        end
      end
      // Sift up: move parents down into the hole until the value fits
      mhs_pkg::S_UP_RD: begin
        if (cur == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent;
        end
      end
      mhs_pkg::S_UP_CMP: begin
        ram_we = 1'b1;
        if (up_less) begin
          ram_wdata = rdata;
          cur_next  = parent;
        end
      end
      // Pop: take root, last entry becomes the hole value
      mhs_pkg::S_POP_R1: begin
        res_val_next = rdata;
        ram_re       = 1'b1;
        ram_raddr    = AW'(cnt - CW'(1));
        cnt_next     = cnt - CW'(1);
      end
      mhs_pkg::S_POP_R2: begin
        val_next   = rdata;
        cur_next   = '0;
        limit_next = cnt;
      end
      mhs_pkg::S_PEEK_R: begin
        res_val_next = rdata;
      end
      // Sort step: root goes to the last unsorted slot
      mhs_pkg::S_SRT_R1: begin
        lval_next = rdata;
        ram_re    = 1'b1;
        ram_raddr = AW'(idx);
      end
      mhs_pkg::S_SRT_R2: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(idx);
        ram_wdata  = lval;
        val_next   = rdata;
        cur_next   = '0;
        limit_next = idx;
      end
      // Sift down: read children, then move the least one up while it is below the hole value
      mhs_pkg::S_DN_RDL: begin
        if (lc >= limit_x) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(lc);
        end
      end
      mhs_pkg::S_DN_RDR: begin
        lval_next = rdata;
        if (rc < limit_x) begin
          ram_re     = 1'b1;
          ram_raddr  = AW'(rc);
          has_r_next = 1'b1;
        end else begin
          has_r_next = 1'b0;
        end
      end
      mhs_pkg::S_DN_CMP: begin
        ram_we = 1'b1;
        if (move) begin
          ram_wdata = best;
          cur_next  = child;
        end
      end
      mhs_pkg::S_SRT_NEXT: begin
        if (idx == CW'(1)) begin
          idx_next = '0;
        end else begin
          idx_next = idx - CW'(1);
          ram_re   = 1'b1;
        end
      end
      // Emit sorted store in index order
      mhs_pkg::S_EM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(idx);
      end
      mhs_pkg::S_EM_OUT: begin
        res_valid        = 1'b1;
        res.result_value = mhs_pkg::VALUE_W'(rdata);
        res.status       = mhs_pkg::ST_OK;
        res.last_of_run  = em_last;
        if (res_ready) idx_next = idx + CW'(1);
      end
      mhs_pkg::S_RESULT: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhs_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_q    <= op_q_next;
    res_st  <= res_st_next;
    res_val <= res_val_next;
    cur     <= cur_next;
    val     <= val_next;
    lval    <= lval_next;
    has_r   <= has_r_next;
    limit   <= limit_next;
    idx     <= idx_next;
  end

endmodule

@@ rtl/min_heap_with_heap_sort.sv @@
// Top level: binary min-heap with in-place heapsort, output register stage.
//
// Usage: the req channel takes one operation per beat (push, pop minimum,
// peek minimum, sort and emit all) with a signed push value. The rsp channel
// returns one beat per push, pop or peek, and one beat per stored entry for
// a sort, the final beat of each operation flagged by last_of_run. Every
// beat carries the entry count after the operation.
// Push moves the value up level by level toward the root; pop takes the root
// and sifts the last entry down from it; peek reads the root; sort runs the
// sort passes and then emits the store. The heap RAM has one write port and
// one read port with registered read data.
// One operation is worked on at a time; the next request is taken once the
// previous result sits in the output register.
// Reset clears the entry count and the sequencer; the heap RAM is not
// cleared, since only entries below the count are ever used.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits on its next result beat.
`timescale 1ns / 1ps

module min_heap_with_heap_sort #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  mhs_req_if.sink   req,
  mhs_rsp_if.source rsp
);

  logic          res_valid;
  logic          res_ready;
  mhs_pkg::rsp_t res;
  logic          out_valid;
  mhs_pkg::rsp_t out_q;

  mhs_engine #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_op    (mhs_pkg::op_t'(req.operation)),
    .req_value (req.push_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output slot free when empty or being drained this cycle
  assign res_ready = !out_valid || rsp.ready;

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_q.result_value;
  assign rsp.status       = out_q.status;
  assign rsp.entry_count  = out_q.entry_count;
  assign rsp.last_of_run  = out_q.last_of_run;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the min-heap with heapsort block.
`timescale 1ns / 1ps

module testbench;

  localparam int HEAP_DEPTH  = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 40;
  localparam int RANDOM_OPS  = 200;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst;

  mhs_req_if req ();
  mhs_rsp_if rsp ();

  min_heap_with_heap_sort #(
    .DEPTH      (HEAP_DEPTH),
    .DATA_WIDTH (mhs_pkg::VALUE_W)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the heap and the beats it predicts
  logic signed [mhs_pkg::VALUE_W-1:0] shadow_heap [HEAP_DEPTH];
  int unsigned                        shadow_count;
  mhs_pkg::rsp_t                      expected_beats [$];

  bit idle_on = 1'b1;
  int rsp_stall = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int ops_sent = 0;
  int beats_checked = 0;
  int sorts_sent = 0;
  int refused_pushes = 0;

  function automatic void heap_swap(int a, int b);
    logic signed [mhs_pkg::VALUE_W-1:0] t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic void sift_down_from(int start, int limit);
    int  cur, least, lc, rc;
    bit  done;
    cur  = start;
    done = 1'b0;
    while (!done) begin
      least = cur;
      lc = 2 * cur + 1;
      rc = 2 * cur + 2;
      if (lc < limit && shadow_heap[lc] < shadow_heap[least]) least = lc;
      if (rc < limit && shadow_heap[rc] < shadow_heap[least]) least = rc;
      if (least == cur) begin
        done = 1'b1;
      end else begin
        heap_swap(cur, least);
        cur = least;
      end
    end
  endfunction

  function automatic void sift_up_from(int pos);
    int parent;
    while (pos != 0) begin
      parent = (pos - 1) / 2;
      if (!(shadow_heap[pos] < shadow_heap[parent])) break;
      heap_swap(pos, parent);
      pos = parent;
    end
  endfunction

  function automatic void queue_beat(logic signed [mhs_pkg::VALUE_W-1:0] value,
                                     mhs_pkg::status_t st, logic last);
    mhs_pkg::rsp_t beat;
    beat.result_value = value;
    beat.status       = st;
    beat.entry_count  = mhs_pkg::COUNT_W'(shadow_count);
    beat.last_of_run  = last;
    expected_beats = {expected_beats, beat};
  endfunction

  // Apply one operation to the shadow heap and queue the beats it yields
  function automatic void predict_heap_op(mhs_pkg::op_t op,
                                          logic signed [mhs_pkg::VALUE_W-1:0] value);
    int i;
    if (op == mhs_pkg::OP_PUSH) begin
      if (shadow_count >= HEAP_DEPTH) begin
        refused_pushes++;
        queue_beat('0, mhs_pkg::ST_FULL, 1'b1);
      end else begin
        shadow_heap[shadow_count] = value;
        shadow_count++;
        sift_up_from(shadow_count - 1);
        queue_beat('0, mhs_pkg::ST_OK, 1'b1);
      end
    end else if (shadow_count == 0) begin
      queue_beat('0, mhs_pkg::ST_EMPTY, 1'b1);
    end else if (op == mhs_pkg::OP_POP) begin
      value = shadow_heap[0];
      shadow_count--;
      shadow_heap[0] = shadow_heap[shadow_count];
      if (shadow_count != 0) sift_down_from(0, shadow_count);
      queue_beat(value, mhs_pkg::ST_OK, 1'b1);
    end else if (op == mhs_pkg::OP_PEEK) begin
      queue_beat(shadow_heap[0], mhs_pkg::ST_OK, 1'b1);
    end else begin
      // in-place heapsort leaves the store in descending order
      for (i = shadow_count - 1; i >= 1; i--) begin
        heap_swap(0, i);
        sift_down_from(0, i);
      end
      for (i = 0; i < shadow_count; i++)
        queue_beat(shadow_heap[i], mhs_pkg::ST_OK, i + 1 == shadow_count);
    end
  endfunction

  // Drive one request beat; valid stays high into the next call when no gap is drawn
  task automatic issue_op(mhs_pkg::op_t op, logic signed [mhs_pkg::VALUE_W-1:0] value);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.push_value <= value;
    predict_heap_op(op, value);
    ops_sent++;
    if (op == mhs_pkg::OP_SORT) sorts_sent++;
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic logic signed [mhs_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1:       return 32'h8000_0000 + $urandom_range(0, 3);
      2, 3, 4: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic mhs_pkg::op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return mhs_pkg::OP_PUSH;
    if (r < 75) return mhs_pkg::OP_POP;
    if (r < 88) return mhs_pkg::OP_PEEK;
    return mhs_pkg::OP_SORT;
  endfunction

  // Empty-heap behavior and a single-entry sort
  task automatic test_empty_heap();
    issue_op(mhs_pkg::OP_POP,  32'h1234_5678);
    issue_op(mhs_pkg::OP_PEEK, 32'hFFFF_FFFF);
    issue_op(mhs_pkg::OP_SORT, 32'h0);
    issue_op(mhs_pkg::OP_PUSH, 32'd42);
    issue_op(mhs_pkg::OP_SORT, 32'h0);
    issue_op(mhs_pkg::OP_PEEK, 32'h0);
    issue_op(mhs_pkg::OP_POP,  32'h0);
    issue_op(mhs_pkg::OP_POP,  32'h0);
  endtask

  // Signed extremes, duplicates, and operations on the sorted layout
  task automatic test_value_extremes();
    issue_op(mhs_pkg::OP_PUSH, 32'h7FFF_FFFF);
    issue_op(mhs_pkg::OP_PUSH, 32'h8000_0000);
    issue_op(mhs_pkg::OP_PUSH, 32'h0000_0000);
    issue_op(mhs_pkg::OP_PUSH, 32'hFFFF_FFFF);
    issue_op(mhs_pkg::OP_PUSH, 32'h0000_0001);
    issue_op(mhs_pkg::OP_PUSH, 32'h5555_5555);
    issue_op(mhs_pkg::OP_PUSH, 32'hAAAA_AAAA);
    issue_op(mhs_pkg::OP_PUSH, 32'hFFFF_FFFF);
    issue_op(mhs_pkg::OP_PEEK, 32'h0);
    issue_op(mhs_pkg::OP_POP,  32'h7FFF_FFFF);
    issue_op(mhs_pkg::OP_POP,  32'h0);
    issue_op(mhs_pkg::OP_SORT, 32'h0);
    issue_op(mhs_pkg::OP_PEEK, 32'h0);
    issue_op(mhs_pkg::OP_PUSH, 32'd5);
    issue_op(mhs_pkg::OP_POP,  32'h0);
    issue_op(mhs_pkg::OP_POP,  32'h0);
    issue_op(mhs_pkg::OP_PEEK, 32'h0);
  endtask

  // Fill to capacity, refused pushes, full sort, then drain past empty
  task automatic test_full_heap();
    idle_on = 1'b0;
    repeat (HEAP_DEPTH) issue_op(mhs_pkg::OP_PUSH, $urandom);
    idle_on = 1'b1;
    issue_op(mhs_pkg::OP_PUSH, 32'h8000_0000);
    issue_op(mhs_pkg::OP_PUSH, 32'h7FFF_FFFF);
    issue_op(mhs_pkg::OP_SORT, 32'h0);
    issue_op(mhs_pkg::OP_PUSH, 32'd0);
    issue_op(mhs_pkg::OP_PEEK, 32'h0);
    repeat (HEAP_DEPTH + 1) issue_op(mhs_pkg::OP_POP, pick_value());
  endtask

  // Random phases: fill bursts, drains and mixed traffic
  task automatic test_random_mix();
    int sent, kind, n;
    sent = 0;
    while (sent < RANDOM_OPS) begin
      kind    = $urandom_range(0, 9);
      idle_on = ($urandom_range(0, 3) != 0);
      if (kind < 2) begin
        n = HEAP_DEPTH - shadow_count + $urandom_range(0, 2);
        repeat (n) issue_op(mhs_pkg::OP_PUSH, pick_value());
        sent += n;
        if ($urandom_range(0, 1)) begin
          issue_op(mhs_pkg::OP_SORT, pick_value());
          sent++;
        end
      end else if (kind < 4) begin
        n = shadow_count + $urandom_range(0, 1);
        repeat (n) issue_op(mhs_pkg::OP_POP, pick_value());
        sent += n;
      end else begin
        repeat (15) issue_op(pick_op(), pick_value());
        sent += 15;
      end
    end
  endtask

  // Result sink: per-beat random stall
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_stall > 0) begin
        rsp.ready <= 1'b0;
        rsp_stall--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    mhs_pkg::rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      rsp_stall = idle_on ? $urandom_range(0, 3) : 0;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected beat value=%0d status=%0d count=%0d last=%0b",
                   $realtime, rsp.result_value, rsp.status, rsp.entry_count,
                   rsp.last_of_run);
      end else begin
        want = expected_beats.pop_front();
        if (rsp.result_value !== want.result_value || rsp.status !== want.status ||
            rsp.entry_count !== want.entry_count || rsp.last_of_run !== want.last_of_run)
        begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: expected value=%0d status=%0d count=%0d last=%0b",
                     $realtime, $signed(want.result_value), want.status,
                     want.entry_count, want.last_of_run);
            $display("%0t:      got value=%0d status=%0d count=%0d last=%0b",
                     $realtime, rsp.result_value, rsp.status, rsp.entry_count,
                     rsp.last_of_run);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles, %0d beats outstanding",
               cycle_count, expected_beats.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    req.valid      = 1'b0;
    req.operation  = mhs_pkg::OP_PUSH;
    req.push_value = '0;
    shadow_count   = 0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_heap();
    test_value_extremes();
    test_full_heap();
    test_random_mix();

    @(negedge clk);
    req.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d operations (%0d sorts, %0d pushes refused on a full heap)",
             ops_sent, sorts_sent, refused_pushes);
    $display("Checked %0d result beats, %0d mismatching", beats_checked, mismatch_count);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
